@@ hdl/quoted_argument_tokenizer_macros.svh @@
// Assertion macros shared by the tokenizer RTL.
`ifndef QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define QAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tokenizer check failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define QAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tokenizer check failed: next-cycle implication");

`endif

@@ hdl/qat_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qat_pkg;

	// Width of the result's token count field and the default counter width.
	localparam int TOKEN_COUNT_W  = 16;
	localparam int COUNT_BITS_DEF = 16;

	// Characters with a special meaning.
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;

	// Scanner mode; the fourth code is never entered and behaves as idle.
	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_PLAIN  = 2'd1,
		MODE_QUOTED = 2'd2
	} qat_mode_t;

	// Scanner control state, apart from the token counter.
	typedef struct packed {
		qat_mode_t mode;
		logic      quote_single;
		logic      escape;
	} qat_ctl_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0]               out_byte;
		logic                     byte_valid;
		logic                     token_start;
		logic                     token_end;
		logic                     string_end;
		logic [TOKEN_COUNT_W-1:0] token_count;
	} qat_result_t;

	// Space, tab, LF, VT, FF and CR separate tokens.
	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

endpackage

`default_nettype wire

@@ hdl/qat_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Per-byte scanner update: result and next state for one input byte.
module qat_step import qat_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic [7:0]            in_byte,
	input  wire logic                  is_last,
	input  wire qat_ctl_t              ctl,
	input  wire logic [COUNT_BITS-1:0] count,
	output qat_ctl_t                   ctl_next,
	output logic [COUNT_BITS-1:0]      count_next,
	output qat_result_t                result
);

	localparam int EXT_W = (COUNT_BITS > TOKEN_COUNT_W) ? COUNT_BITS : TOKEN_COUNT_W;
	localparam logic [EXT_W-1:0] SHOW_MAX = EXT_W'({TOKEN_COUNT_W{1'b1}});

	logic                  ws;
	logic                  keep;
	logic                  start;
	logic                  term;
	qat_ctl_t              c;
	logic [COUNT_BITS-1:0] cnt;
	logic [EXT_W-1:0]      cnt_ext;
	logic [7:0]            match;

	assign ws = is_ws(in_byte);

	// Mode update, in the order the scanner applies its rules.
	always_comb begin
		c     = ctl;
		cnt   = count;
		keep  = 1'b0;
		start = 1'b0;
		term  = 1'b0;

		// Between tokens, any non-whitespace byte opens a token.
		if ((c.mode != MODE_PLAIN) && (c.mode != MODE_QUOTED)) begin
			c.mode = MODE_IDLE;
			if (!ws) begin
				start    = 1'b1;
				if (cnt != {COUNT_BITS{1'b1}}) begin
					cnt = cnt + 1'b1;
				end
				c.mode   = MODE_PLAIN;
				c.escape = 1'b0;
			end
		end

		match = c.quote_single ? CH_SQUOTE : CH_DQUOTE;

		// Inside a token: escapes, quotes and separators.
		if (c.mode != MODE_IDLE) begin
			priority if (c.escape) begin
				keep     = 1'b1;
				c.escape = 1'b0;
			end else if (in_byte == CH_BACKSLASH) begin
				c.escape = 1'b1;
			end else if (c.mode == MODE_PLAIN) begin
				priority if (ws) begin
					term   = 1'b1;
					c.mode = MODE_IDLE;
				end else if ((in_byte == CH_SQUOTE) || (in_byte == CH_DQUOTE)) begin
					c.mode         = MODE_QUOTED;
					c.quote_single = (in_byte == CH_SQUOTE);
				end else begin
					keep = 1'b1;
				end
			end else begin
				if (in_byte == match) begin
					c.mode = MODE_PLAIN;
				end else begin
					keep = 1'b1;
				end
			end
		end

		cnt_ext = EXT_W'(cnt);

		result.out_byte    = keep ? in_byte : 8'h00;
		result.byte_valid  = keep;
		result.token_start = start;
		result.token_end   = term || (is_last && (c.mode != MODE_IDLE));
		result.string_end  = is_last;
		result.token_count = (cnt_ext > SHOW_MAX) ? {TOKEN_COUNT_W{1'b1}}
		                                          : cnt_ext[TOKEN_COUNT_W-1:0];

		// The end of the string returns everything to its reset value.
		if (is_last) begin
			ctl_next   = '{mode: MODE_IDLE, quote_single: 1'b0, escape: 1'b0};
			count_next = '0;
		end else begin
			ctl_next   = c;
			count_next = cnt;
		end
	end

endmodule

`default_nettype wire

@@ hdl/quoted_argument_tokenizer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// input     in_valid / in_ready        in_byte, is_last
// output    out_valid / out_ready      out_byte, byte_valid, token_start,
//                                      token_end, string_end, token_count
//
// One byte per cycle sustained while out_ready stays high; a result reaches the output
// through the input register, then the scanner update into the result register.
// The scanner state lives next to the result register and is updated when a byte
// moves into it, so consecutive bytes see each other's effect without a bubble.
// arst_n clears both stage valids, the scanner mode and the token counter.
// A stalled output holds the result; the input register still takes one more byte.
module quoted_argument_tokenizer import qat_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [7:0]               in_byte,
	input  wire logic                     is_last,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [7:0]                    out_byte,
	output logic                          byte_valid,
	output logic                          token_start,
	output logic                          token_end,
	output logic                          string_end,
	output logic [TOKEN_COUNT_W-1:0]      token_count
);

`include "quoted_argument_tokenizer_macros.svh"

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic                  advance;
	qat_ctl_t              ctl_q;
	qat_ctl_t              ctl_next;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_next;
	qat_result_t           result;
	qat_result_t           result_s2;
	logic                  valid_s2;

	// A byte moves on when the result register is empty or being drained.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= is_last;
		end
	end

	qat_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.in_byte   (byte_s1),
		.is_last   (last_s1),
		.ctl       (ctl_q),
		.count     (count_q),
		.ctl_next  (ctl_next),
		.count_next(count_next),
		.result    (result)
	);

	// Scanner state, updated once per byte that reaches the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= '{mode: MODE_IDLE, quote_single: 1'b0, escape: 1'b0};
			count_q <= '0;
		end else if (advance) begin
			ctl_q   <= ctl_next;
			count_q <= count_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign out_byte    = result_s2.out_byte;
	assign byte_valid  = result_s2.byte_valid;
	assign token_start = result_s2.token_start;
	assign token_end   = result_s2.token_end;
	assign string_end  = result_s2.string_end;
	assign token_count = result_s2.token_count;

	// A pending escape only exists inside a token.
	`QAT_ASSERT_NOW(a_escape_in_token, clk, arst_n, ctl_q.escape, ctl_q.mode != MODE_IDLE)
	// The end of a string leaves the scanner in its reset state.
	`QAT_ASSERT_NEXT(a_string_end_resets, clk, arst_n, advance && last_s1,
		(ctl_q.mode == MODE_IDLE) && (count_q == '0) && !ctl_q.escape)
	// Dropped bytes are shown as zero.
	`QAT_ASSERT_NOW(a_dropped_zero, clk, arst_n, out_valid && !byte_valid, out_byte == 8'h00)
	// A started token is always counted.
	`QAT_ASSERT_NOW(a_start_counted, clk, arst_n, out_valid && token_start, token_count != '0)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import qat_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RANDOM_BYTES = 1350;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 80;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_SPAN   = 150;

	// Characters that the package does not name.
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_VT        = 8'h0B;
	localparam logic [7:0] CH_FF        = 8'h0C;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_SO        = 8'h0E;

	// One byte of a command line waiting to be sent.
	typedef struct packed {
		logic [7:0] ch;
		logic       ends_line;
	} line_char_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic [7:0]               in_byte   = 8'h00;
	logic                     is_last   = 1'b0;
	logic                     out_ready = 1'b0;
	logic                     in_ready;
	logic                     out_valid;
	logic [7:0]               out_byte;
	logic                     byte_valid;
	logic                     token_start;
	logic                     token_end;
	logic                     string_end;
	logic [TOKEN_COUNT_W-1:0] token_count;

	line_char_t  pending_chars[$];
	logic [7:0]  line_buf[$];
	qat_result_t expected_results[$];

	// Shadow copy of the scanner state.
	qat_mode_t                scan_state;
	logic                     in_single_quote;
	logic                     escape_next;
	logic [TOKEN_COUNT_W-1:0] tokens_started;

	int mismatches     = 0;
	int bytes_accepted = 0;
	int results_seen   = 0;
	int lines_queued   = 0;
	int tokens_checked = 0;
	int max_count_seen = 0;
	int send_gap       = 0;
	int ready_wait     = 0;
	int hold_left      = 0;
	int held_cycles    = 0;
	int quiet_cycles   = 0;

	quoted_argument_tokenizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.token_start(token_start),
		.token_end  (token_end),
		.string_end (string_end),
		.token_count(token_count)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Separators are space and the five control codes from tab to CR.
	function automatic logic is_separator(input logic [7:0] b);
		case (b)
			CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void clear_scanner();
		scan_state      = MODE_IDLE;
		in_single_quote = 1'b0;
		escape_next     = 1'b0;
		tokens_started  = '0;
	endfunction

	// Advances the shadow scanner by one byte and returns the result it implies.
	function automatic qat_result_t split_next_byte(input logic [7:0] b, input logic ends_line);
		qat_result_t r;
		logic        keep;
		logic        begins;
		logic        closes;
		keep   = 1'b0;
		begins = 1'b0;
		closes = 1'b0;
		// Between tokens, any non-separator opens a new token.
		if (scan_state != MODE_PLAIN && scan_state != MODE_QUOTED) begin
			scan_state = MODE_IDLE;
			if (!is_separator(b)) begin
				begins = 1'b1;
				if (tokens_started != '1)
					tokens_started = tokens_started + 1'b1;
				scan_state  = MODE_PLAIN;
				escape_next = 1'b0;
			end
		end
		// Inside a token: escapes, quotes and separators.
		if (scan_state != MODE_IDLE) begin
			if (escape_next) begin
				keep        = 1'b1;
				escape_next = 1'b0;
			end else if (b == CH_BACKSLASH) begin
				escape_next = 1'b1;
			end else if (scan_state == MODE_PLAIN) begin
				if (is_separator(b)) begin
					closes     = 1'b1;
					scan_state = MODE_IDLE;
				end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
					scan_state      = MODE_QUOTED;
					in_single_quote = (b == CH_SQUOTE);
				end else begin
					keep = 1'b1;
				end
			end else begin
				if (b == (in_single_quote ? CH_SQUOTE : CH_DQUOTE))
					scan_state = MODE_PLAIN;
				else
					keep = 1'b1;
			end
		end
		r.token_count = tokens_started;
		// The last byte closes any open token and clears the scanner.
		if (ends_line) begin
			if (scan_state != MODE_IDLE)
				closes = 1'b1;
			clear_scanner();
		end
		r.out_byte    = keep ? b : 8'h00;
		r.byte_valid  = keep;
		r.token_start = begins;
		r.token_end   = closes;
		r.string_end  = ends_line;
		return r;
	endfunction

	// Moves the assembled line into the send queue, marking its last byte.
	task automatic flush_line();
		for (int i = 0; i < line_buf.size(); i++)
			pending_chars.push_back({line_buf[i], (i == line_buf.size() - 1) ? 1'b1 : 1'b0});
		line_buf.delete();
		lines_queued++;
	endtask

	function automatic logic [7:0] pick_separator();
		case ($urandom_range(0, 5))
			0: return CH_TAB;
			1: return CH_LF;
			2: return CH_VT;
			3: return CH_FF;
			4: return CH_CR;
			default: return CH_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] pick_plain();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	// A quoted segment holding separators, the other quote and escapes.
	task automatic add_quoted();
		logic [7:0] q;
		q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
		line_buf.push_back(q);
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 5))
				0: line_buf.push_back(pick_separator());
				1: line_buf.push_back((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
				2: begin
					line_buf.push_back(CH_BACKSLASH);
					line_buf.push_back(8'($urandom_range(0, 255)));
				end
				default: line_buf.push_back(pick_plain());
			endcase
		end
		// Now and then the quote is left open.
		if ($urandom_range(0, 7) != 0)
			line_buf.push_back(q);
	endtask

	task automatic add_word();
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 4))
				0, 1: repeat ($urandom_range(1, 4)) line_buf.push_back(pick_plain());
				2: begin
					line_buf.push_back(CH_BACKSLASH);
					line_buf.push_back(8'($urandom_range(0, 255)));
				end
				default: add_quoted();
			endcase
		end
	endtask

	// A command line of one to six words; a quote may be left open.
	task automatic add_command_line();
		int words;
		words = $urandom_range(1, 6);
		if ($urandom_range(0, 1))
			repeat ($urandom_range(1, 3)) line_buf.push_back(pick_separator());
		for (int w = 0; w < words; w++) begin
			if (w > 0)
				repeat ($urandom_range(1, 3)) line_buf.push_back(pick_separator());
			add_word();
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) line_buf.push_back(pick_separator());
		flush_line();
	endtask

	// Noise: random bytes, biased toward the characters that matter.
	task automatic add_noise_line();
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(0, 4))
				0: line_buf.push_back(pick_separator());
				1: line_buf.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
				2: line_buf.push_back(CH_BACKSLASH);
				default: line_buf.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		flush_line();
	endtask

	// Many one-letter tokens, so the count climbs higher.
	task automatic add_long_line();
		repeat ($urandom_range(60, 120)) begin
			line_buf.push_back(pick_plain());
			line_buf.push_back(CH_SPACE);
		end
		flush_line();
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at result %0d: %s", results_seen, msg);
	endtask

	task automatic check_result(input qat_result_t want);
		if (out_byte !== want.out_byte)
			report_mismatch($sformatf("out_byte 0x%0h, expected 0x%0h", out_byte, want.out_byte));
		if (byte_valid !== want.byte_valid)
			report_mismatch($sformatf("byte_valid %b, expected %b", byte_valid, want.byte_valid));
		if (token_start !== want.token_start)
			report_mismatch($sformatf("token_start %b, expected %b", token_start, want.token_start));
		if (token_end !== want.token_end)
			report_mismatch($sformatf("token_end %b, expected %b", token_end, want.token_end));
		if (string_end !== want.string_end)
			report_mismatch($sformatf("string_end %b, expected %b", string_end, want.string_end));
		if (token_count !== want.token_count)
			report_mismatch($sformatf("token_count %0d, expected %0d", token_count, want.token_count));
	endtask

	// Input driver: one transaction per queued byte, with a random gap after each outside the gapless stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte  <= 8'h00;
			is_last  <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(split_next_byte(in_byte, is_last));
				bytes_accepted++;
				if (((bytes_accepted / QUIET_SPAN) % 4) == 2)
					send_gap = 0;
				else
					send_gap = $urandom_range(0, 4);
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					line_char_t next_char;
					next_char = pending_chars.pop_front();
					in_valid <= 1'b1;
					in_byte  <= next_char.ch;
					is_last  <= next_char.ends_line;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each result transaction and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_wait = 0;
			hold_left  = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("result transaction with nothing expected");
				end else begin
					check_result(expected_results.pop_front());
				end
				if (token_start)
					tokens_checked++;
				if (int'(token_count) > max_count_seen)
					max_count_seen = int'(token_count);
				if (((results_seen / QUIET_SPAN) % 4) == 2)
					ready_wait = 0;
				else
					ready_wait = $urandom_range(0, 4);
				// One long stall so the block fills and pushes back on its input.
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				held_cycles++;
				out_ready <= 1'b0;
			end else if (ready_wait > 0) begin
				ready_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("[quoted_argument_tokenizer] ERROR");
				$finish;
			end
		end
	end

	// Stimulus, then wait for the results to drain and report.
	initial begin
		clear_scanner();

		// Separators in and out of a token, control and high bytes, zero byte.
		line_buf = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_BACKSPACE, CH_SO,
			CH_SPACE, 8'h00, 8'hFF};
		flush_line();
		// A single-byte line.
		line_buf = '{8'h61};
		flush_line();
		// An empty argument made only of quotes.
		line_buf = '{CH_DQUOTE, CH_DQUOTE};
		flush_line();
		// Single quotes keep a double quote and a space; a trailing backslash is dropped.
		line_buf = '{CH_SQUOTE, CH_DQUOTE, CH_SPACE, CH_SQUOTE, CH_BACKSLASH};
		flush_line();
		// Escaped backslash and quote, then a quote left open at the end.
		line_buf = '{CH_BACKSLASH, CH_BACKSLASH, CH_DQUOTE, CH_BACKSLASH, CH_DQUOTE, 8'h80};
		flush_line();

		while (pending_chars.size() < RANDOM_BYTES + 25) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 75)
				add_command_line();
			else if (pick < 97)
				add_noise_line();
			else
				add_long_line();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d command lines; checked %0d results, %0d tokens.",
			bytes_accepted, lines_queued, results_seen, tokens_checked);
		$display("Highest token count seen %0d; output held off for %0d cycles in one stretch.",
			max_count_seen, held_cycles);
		if (mismatches == 0) begin
			$display("[quoted_argument_tokenizer] OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[quoted_argument_tokenizer] ERROR");
		end
		$finish;
	end

endmodule
